// ----- hw/rtl/ecpa_pkg.sv -----
// Shared types, constants and the instruction program of the affine point adder.
package ecpa_pkg;

  localparam int OPA_W = 32;   // multiplier operand A width, bits walked per multiply
  localparam int PC_W  = 6;

  typedef enum logic [2:0] {
    OP_MUL, OP_ADD, OP_SUB, OP_SELZ, OP_CMP, OP_EACC, OP_ESQR, OP_END
  } op_t;

  // register file slots
  localparam logic [3:0] R_X1   = 4'd0;
  localparam logic [3:0] R_Y1   = 4'd1;
  localparam logic [3:0] R_X2   = 4'd2;
  localparam logic [3:0] R_Y2   = 4'd3;
  localparam logic [3:0] R_A    = 4'd4;
  localparam logic [3:0] R_B    = 4'd5;
  localparam logic [3:0] R_BASE = 4'd6;
  localparam logic [3:0] R_ACC  = 4'd7;
  localparam logic [3:0] R_M    = 4'd8;
  localparam logic [3:0] R_X3   = 4'd9;
  localparam logic [3:0] R_Y3   = 4'd10;
  localparam logic [3:0] R_T1   = 4'd11;
  localparam logic [3:0] R_T2   = 4'd12;
  localparam logic [3:0] R_T3   = 4'd13;

  // operand sources outside the register file (bit 4 set)
  localparam logic [4:0] SRC_IN_X1 = 5'd16;
  localparam logic [4:0] SRC_IN_Y1 = 5'd17;
  localparam logic [4:0] SRC_IN_X2 = 5'd18;
  localparam logic [4:0] SRC_IN_Y2 = 5'd19;
  localparam logic [4:0] SRC_CFG_A = 5'd20;
  localparam logic [4:0] SRC_CFG_B = 5'd21;
  localparam logic [4:0] SRC_ONE   = 5'd22;
  localparam logic [4:0] SRC_ZERO  = 5'd23;

  // flag targets of OP_CMP, carried in the dst field
  localparam logic [3:0] FLG_EQ = 4'd0;
  localparam logic [3:0] FLG_C1 = 4'd1;
  localparam logic [3:0] FLG_C2 = 4'd2;

  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_CURVE_A = 2'd1;
  localparam logic [1:0] REG_CURVE_B = 2'd2;

  typedef struct packed {
    op_t        op;
    logic [3:0] dst;
    logic [4:0] sa;
    logic [4:0] sb;
  } instr_t;

  typedef struct packed {
    logic [30:0] first_x;
    logic [30:0] first_y;
    logic [30:0] second_x;
    logic [30:0] second_y;
  } in_item_t;

  typedef struct packed {
    logic [30:0] sum_x;
    logic [30:0] sum_y;
    logic        first_on_curve;
    logic        second_on_curve;
    logic        equal_x;
  } out_item_t;

  typedef struct packed {
    logic   load;
    logic   go;
    instr_t ins;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic ebit;
  } dp_stat_t;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_DONE} ctrl_state_t;
  typedef enum logic {PH_IDLE, PH_EXEC} dp_phase_t;

  localparam logic [PC_W-1:0] PC_EACC = 6'd9;

  function automatic logic [4:0] sr(logic [3:0] r);
    return {1'b0, r};
  endfunction

  function automatic instr_t mk(op_t op, logic [3:0] dst, logic [4:0] sa, logic [4:0] sb);
    instr_t i;
    i.op  = op;
    i.dst = dst;
    i.sa  = sa;
    i.sb  = sb;
    return i;
  endfunction

  function automatic instr_t prog_rom(logic [PC_W-1:0] pc);
    instr_t i;
    case (pc)
      6'd0:  i = mk(OP_MUL,  R_X1,   SRC_IN_X1,  SRC_ONE);
      6'd1:  i = mk(OP_MUL,  R_Y1,   SRC_IN_Y1,  SRC_ONE);
      6'd2:  i = mk(OP_MUL,  R_X2,   SRC_IN_X2,  SRC_ONE);
      6'd3:  i = mk(OP_MUL,  R_Y2,   SRC_IN_Y2,  SRC_ONE);
      6'd4:  i = mk(OP_MUL,  R_A,    SRC_CFG_A,  SRC_ONE);
      6'd5:  i = mk(OP_MUL,  R_B,    SRC_CFG_B,  SRC_ONE);
      6'd6:  i = mk(OP_SUB,  R_BASE, sr(R_X1),   sr(R_X2));
      6'd7:  i = mk(OP_CMP,  FLG_EQ, sr(R_X1),   sr(R_X2));
      6'd8:  i = mk(OP_ADD,  R_ACC,  SRC_ONE,    SRC_ZERO);
      6'd9:  i = mk(OP_EACC, R_ACC,  sr(R_ACC),  sr(R_BASE));
      6'd10: i = mk(OP_ESQR, R_BASE, sr(R_BASE), sr(R_BASE));
      6'd11: i = mk(OP_SELZ, R_ACC,  sr(R_ACC),  SRC_ZERO);
      6'd12: i = mk(OP_SUB,  R_T1,   sr(R_Y1),   sr(R_Y2));
      6'd13: i = mk(OP_MUL,  R_M,    sr(R_T1),   sr(R_ACC));
      6'd14: i = mk(OP_MUL,  R_T2,   sr(R_M),    sr(R_X2));
      6'd15: i = mk(OP_SUB,  R_T3,   sr(R_Y2),   sr(R_T2));
      6'd16: i = mk(OP_MUL,  R_T1,   sr(R_M),    sr(R_M));
      6'd17: i = mk(OP_SUB,  R_T1,   sr(R_T1),   sr(R_X1));
      6'd18: i = mk(OP_SUB,  R_X3,   sr(R_T1),   sr(R_X2));
      6'd19: i = mk(OP_MUL,  R_T2,   sr(R_M),    sr(R_X3));
      6'd20: i = mk(OP_ADD,  R_Y3,   sr(R_T2),   sr(R_T3));
      6'd21: i = mk(OP_MUL,  R_T1,   sr(R_Y1),   sr(R_Y1));
      6'd22: i = mk(OP_MUL,  R_T2,   sr(R_X1),   sr(R_X1));
      6'd23: i = mk(OP_MUL,  R_T2,   sr(R_T2),   sr(R_X1));
      6'd24: i = mk(OP_MUL,  R_T3,   sr(R_A),    sr(R_X1));
      6'd25: i = mk(OP_ADD,  R_T2,   sr(R_T2),   sr(R_T3));
      6'd26: i = mk(OP_ADD,  R_T2,   sr(R_T2),   sr(R_B));
      6'd27: i = mk(OP_CMP,  FLG_C1, sr(R_T1),   sr(R_T2));
      6'd28: i = mk(OP_MUL,  R_T1,   sr(R_Y2),   sr(R_Y2));
      6'd29: i = mk(OP_MUL,  R_T2,   sr(R_X2),   sr(R_X2));
      6'd30: i = mk(OP_MUL,  R_T2,   sr(R_T2),   sr(R_X2));
      6'd31: i = mk(OP_MUL,  R_T3,   sr(R_A),    sr(R_X2));
      6'd32: i = mk(OP_ADD,  R_T2,   sr(R_T2),   sr(R_T3));
      6'd33: i = mk(OP_ADD,  R_T2,   sr(R_T2),   sr(R_B));
      6'd34: i = mk(OP_CMP,  FLG_C2, sr(R_T1),   sr(R_T2));
      default: i = mk(OP_END, R_X1, SRC_ZERO, SRC_ZERO);
    endcase
    return i;
  endfunction

endpackage

// ----- hw/rtl/ecpa_datapath.sv -----
// Datapath: register file, serial modular multiplier, add/sub/compare and exponent shifter.
module ecpa_datapath import ecpa_pkg::*; #(
  parameter int FIELD_WIDTH = 31
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  input  in_item_t               in_data,
  input  logic [FIELD_WIDTH-1:0] cfg_modulus,
  input  logic [FIELD_WIDTH-1:0] cfg_a,
  input  logic [FIELD_WIDTH-1:0] cfg_b,
  output out_item_t              res
);

  localparam int W     = FIELD_WIDTH;
  localparam int CNT_W = $clog2(OPA_W);

  logic [W-1:0]     mem [16];
  dp_phase_t        ph_r, ph_nxt;
  instr_t           ins_r;
  logic [W-1:0]     rda_r, rdb_r;
  in_item_t         in_r;
  logic [W-1:0]     e_r;
  logic [W-1:0]     acc_r;
  logic [CNT_W-1:0] cnt_r;
  logic [2:0]       flag_r;
  logic [W-1:0]     sumx_r, sumy_r;

  logic [W-1:0]     p, one, b_val, wr_data, step, add_res, sub_res;
  logic [OPA_W-1:0] a_val;
  logic [W:0]       t0, t1, u0, u1, s0, d0, pe;
  logic             wr_en, flag_we, e_shift, done, is_mul;

  assign p   = (cfg_modulus == '0) ? W'(1) : cfg_modulus;
  assign one = (p == W'(1)) ? '0 : W'(1);
  assign pe  = {1'b0, p};

  always_comb begin
    case (ins_r.sa)
      SRC_IN_X1: a_val = OPA_W'(in_r.first_x);
      SRC_IN_Y1: a_val = OPA_W'(in_r.first_y);
      SRC_IN_X2: a_val = OPA_W'(in_r.second_x);
      SRC_IN_Y2: a_val = OPA_W'(in_r.second_y);
      SRC_CFG_A: a_val = OPA_W'(cfg_a);
      SRC_CFG_B: a_val = OPA_W'(cfg_b);
      SRC_ONE:   a_val = OPA_W'(one);
      SRC_ZERO:  a_val = '0;
      default:   a_val = OPA_W'(rda_r);
    endcase
    if (!ins_r.sb[4])             b_val = rdb_r;
    else if (ins_r.sb == SRC_ONE) b_val = one;
    else                          b_val = '0;
  end

  // one MSB-first step of interleaved modular multiply: acc = 2*acc + bit*b mod p
  always_comb begin
    t0   = {acc_r, 1'b0};
    t1   = (t0 >= pe) ? t0 - pe : t0;
    u0   = t1 + (a_val[cnt_r] ? {1'b0, b_val} : '0);
    u1   = (u0 >= pe) ? u0 - pe : u0;
    step = u1[W-1:0];
    s0   = {1'b0, a_val[W-1:0]} + {1'b0, b_val};
    add_res = (s0 >= pe) ? W'(s0 - pe) : s0[W-1:0];
    d0   = {1'b0, a_val[W-1:0]} + pe - {1'b0, b_val};
    sub_res = (a_val[W-1:0] >= b_val) ? a_val[W-1:0] - b_val : d0[W-1:0];
  end

  assign is_mul = (ins_r.op == OP_MUL) || (ins_r.op == OP_EACC) || (ins_r.op == OP_ESQR);

  always_comb begin
    ph_nxt  = ph_r;
    done    = 1'b0;
    wr_en   = 1'b0;
    wr_data = '0;
    flag_we = 1'b0;
    e_shift = 1'b0;
    case (ph_r)
      PH_IDLE: begin
        if (cmd.go) ph_nxt = PH_EXEC;
      end
      PH_EXEC: begin
        case (ins_r.op)
          OP_MUL, OP_EACC, OP_ESQR: begin
            if (cnt_r == '0) begin
              done    = 1'b1;
              wr_en   = 1'b1;
              wr_data = step;
              e_shift = (ins_r.op == OP_ESQR);
            end
          end
          OP_ADD: begin
            done = 1'b1; wr_en = 1'b1; wr_data = add_res;
          end
          OP_SUB: begin
            done = 1'b1; wr_en = 1'b1; wr_data = sub_res;
          end
          OP_SELZ: begin
            done = 1'b1; wr_en = 1'b1;
            wr_data = flag_r[0] ? '0 : a_val[W-1:0];
          end
          OP_CMP: begin
            done = 1'b1; flag_we = 1'b1;
          end
          default: done = 1'b1;
        endcase
        if (done) ph_nxt = PH_IDLE;
      end
      default: ph_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      rda_r <= mem[cmd.ins.sa[3:0]];
      rdb_r <= mem[cmd.ins.sb[3:0]];
    end
    if (wr_en) mem[ins_r.dst] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_IDLE;
    end else begin
      ph_r <= ph_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
      e_r  <= (p < W'(2)) ? '0 : p - W'(2);
    end else if (e_shift) begin
      e_r <= e_r >> 1;
    end
    if (cmd.go) begin
      ins_r <= cmd.ins;
      acc_r <= '0;
      cnt_r <= CNT_W'(OPA_W - 1);
    end else if (ph_r == PH_EXEC && is_mul) begin
      acc_r <= step;
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (flag_we) begin
      case (ins_r.dst)
        FLG_EQ:  flag_r[0] <= (a_val[W-1:0] == b_val);
        FLG_C1:  flag_r[1] <= (a_val[W-1:0] == b_val);
        FLG_C2:  flag_r[2] <= (a_val[W-1:0] == b_val);
        default: flag_r <= flag_r;
      endcase
    end
    if (wr_en && ins_r.dst == R_X3) sumx_r <= wr_data;
    if (wr_en && ins_r.dst == R_Y3) sumy_r <= wr_data;
  end

  assign stat.done = done;
  assign stat.ebit = e_r[0];

  assign res.sum_x           = 31'(sumx_r);
  assign res.sum_y           = 31'(sumy_r);
  assign res.first_on_curve  = flag_r[1];
  assign res.second_on_curve = flag_r[2];
  assign res.equal_x         = flag_r[0];

endmodule

// ----- hw/rtl/ecpa_ctrl.sv -----
// Controller: program sequencer with the square-and-multiply loop.
module ecpa_ctrl import ecpa_pkg::*; #(
  parameter int FIELD_WIDTH = 31
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     out_valid
);

  localparam int CW = $clog2(FIELD_WIDTH);

  ctrl_state_t     state_r, state_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  instr_t          ins;

  assign ins = prog_rom(pc_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    cnt_nxt   = cnt_r;
    cmd.load  = 1'b0;
    cmd.go    = 1'b0;
    cmd.ins   = ins;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          pc_nxt    = '0;
          cnt_nxt   = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (ins.op == OP_END) begin
          state_nxt = ST_DONE;
        end else if (ins.op == OP_EACC && !stat.ebit) begin
          pc_nxt = pc_r + PC_W'(1);  // exponent bit clear: skip the multiply
        end else begin
          cmd.go    = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (stat.done) begin
          state_nxt = ST_ISSUE;
          if (ins.op == OP_ESQR && cnt_r != CW'(FIELD_WIDTH - 1)) begin
            cnt_nxt = cnt_r + CW'(1);
            pc_nxt  = PC_EACC;
          end else begin
            cnt_nxt = '0;
            pc_nxt  = pc_r + PC_W'(1);
          end
        end
      end
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// ----- hw/rtl/ec_affine_point_add_mod_p.sv -----
// Top level: affine point adder over a configurable prime field.
//
//  channel  ports                                    handshake
//  input    start, busy, in_data                     taken when start && !busy
//  result   out_valid, out_data                      one-cycle strobe, no backpressure
//  config   psel penable pwrite paddr pwdata prdata  APB write, pready tied high
//
// A transaction performs 18 fixed products, FIELD_WIDTH squarings and k multiplies, k the set bits of modulus-2;
// each multiply and each add/sub/compare is issued and then executed in the datapath, the multiply as
// serial steps.
// busy stays high from acceptance until the cycle of the out_valid strobe.
// Synchronous active-low reset returns the sequencer to idle and the config registers to defaults.
// No stall path: the result is presented once and must be taken.
module ec_affine_point_add_mod_p import ecpa_pkg::*; #(
  parameter int FIELD_WIDTH = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_data,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [FIELD_WIDTH-1:0] modulus_r, curve_a_r, curve_b_r;
  logic                   wr;
  dp_cmd_t                cmd;
  dp_stat_t               stat;
  logic                   busy_i;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= FIELD_WIDTH'(32'h7FFF_FFFF);
      curve_a_r <= '0;
      curve_b_r <= '0;
    end else if (wr) begin
      case (paddr[3:2])
        REG_MODULUS: modulus_r <= pwdata[FIELD_WIDTH-1:0];
        REG_CURVE_A: curve_a_r <= pwdata[FIELD_WIDTH-1:0];
        REG_CURVE_B: curve_b_r <= pwdata[FIELD_WIDTH-1:0];
        default:     modulus_r <= modulus_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODULUS: prdata = 32'(modulus_r);
      REG_CURVE_A: prdata = 32'(curve_a_r);
      REG_CURVE_B: prdata = 32'(curve_b_r);
      default:     prdata = '0;
    endcase
  end

  ecpa_ctrl #(.FIELD_WIDTH(FIELD_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy_i),
    .out_valid (out_valid)
  );

  ecpa_datapath #(.FIELD_WIDTH(FIELD_WIDTH)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_data     (in_data),
    .cfg_modulus (modulus_r),
    .cfg_a       (curve_a_r),
    .cfg_b       (curve_b_r),
    .res         (out_data)
  );

  assign busy = busy_i;

endmodule

// ----- hw/rtl/ecpa_checker.sv -----
// Port-level checker for the point adder, bound to the top level.
module ecpa_checker import ecpa_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_data
);

  // accepted transaction keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised after accept");

  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside a transaction");

  a_strobe_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy held after result");

  // the equal-x flag is written early in every transaction
  a_eq_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_data.equal_x)) else $error("equal_x unknown");

endmodule

bind ec_affine_point_add_mod_p ecpa_checker u_ecpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
